/* sv/pcmdma_pkg.sv */
// shared types, codes and constants for the pcm playback dma channel
// no dependencies; imported by every module of the block
package pcmdma_pkg;

  localparam int FIFO_BYTES = 32;
  localparam int POS_W      = $clog2(FIFO_BYTES);
  localparam int LANE_ROWS  = FIFO_BYTES / 4;
  localparam int ROW_W      = POS_W - 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // room check: one more word fits while the level is at most this
  localparam logic [31:0] ROOM_LIMIT = 32'(FIFO_BYTES - 4);

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_CLEAR_IRQ = 3'd2,
    OP_DMA_REQ   = 3'd3,
    OP_DMA_FILL  = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    FMT_MONO8     = 2'd0,
    FMT_STEREO8   = 2'd1,
    FMT_MONO16    = 2'd2,
    FMT_STEREO16  = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS     = 3'd0,
    REG_BUFFER_FRAMES    = 3'd1,
    REG_FRAGMENT_FRAMES  = 3'd2,
    REG_SAMPLE_FORMAT    = 3'd3,
    REG_INTERRUPT_ENABLE = 3'd4,
    REG_FREE_RUN         = 3'd5,
    REG_PAUSED           = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               fetch_valid;
    logic [31:0]        fetch_address;
    logic               irq;
    logic [15:0]        frames_left;
    logic [15:0]        samples_left_quarter;
  } res_t;

  // 17-bit counter step with a floor at the most negative value
  function automatic logic signed [16:0] count_down(input logic signed [16:0] c);
    logic signed [16:0] r;
    if (c == 17'sh10000) begin
      r = c;
    end else begin
      r = c - 17'sd1;
    end
    return r;
  endfunction

  // 8-bit sample: flip the sign bit and move to the upper byte
  function automatic logic [15:0] unpack8(input logic [7:0] b);
    return {b ^ 8'h80, 8'h00};
  endfunction

endpackage

/* sv/pcmdma_cmd_if.sv */
// command channel: operation and fetched memory word
// depends on nothing but the handshake signals it carries
interface pcmdma_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] mem_word;

  modport source (output valid, output operation, output mem_word, input ready);
  modport sink   (input valid, input operation, input mem_word, output ready);
endinterface

/* sv/pcmdma_res_if.sv */
// result channel: samples, fetch request and status per command word
// depends on nothing but the handshake signals it carries
interface pcmdma_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               fetch_valid;
  logic [31:0]        fetch_address;
  logic               irq;
  logic [15:0]        frames_left;
  logic [15:0]        samples_left_quarter;

  modport source (output valid, output left_sample, output right_sample,
                  output fetch_valid, output fetch_address, output irq,
                  output frames_left, output samples_left_quarter, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input fetch_valid, input fetch_address, input irq,
                  input frames_left, input samples_left_quarter, output ready);
endinterface

/* sv/pcmdma_fifo.sv */
// sample fifo as four byte lanes, one word written, four bytes read a cycle
// depends on pcmdma_pkg
module pcmdma_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [pcmdma_pkg::ROW_W-1:0] wr_row,
  input  logic [31:0]                 wr_word,
  input  logic [pcmdma_pkg::POS_W-1:0] rd_pos,
  output logic [3:0][7:0]             rd_bytes
);
  import pcmdma_pkg::*;

  logic [LANE_ROWS-1:0][7:0] lane_mem [4];
  logic [3:0][7:0]           lane_byte;

  // each lane is written at the same row, a word is always lane aligned
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 4; j++) begin
        lane_mem[j] <= '0;
      end
    end else if (wr_en) begin
      for (int j = 0; j < 4; j++) begin
        lane_mem[j][wr_row] <= wr_word[8*j +: 8];
      end
    end
  end

  // each lane supplies the one byte of the window that falls in it
  always_comb begin
    logic [1:0]       k;
    logic [POS_W-1:0] pos;
    for (int j = 0; j < 4; j++) begin
      k            = 2'(j) - rd_pos[1:0];
      pos          = rd_pos + POS_W'(k);
      lane_byte[j] = lane_mem[j][pos[POS_W-1:2]];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_bytes[k] = lane_byte[rd_pos[1:0] + 2'(k)];
    end
  end

endmodule

/* sv/pcmdma_out_skid.sv */
// result register with a skid stage so the command side keeps flowing
// depends on pcmdma_pkg
module pcmdma_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcmdma_pkg::res_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcmdma_pkg::res_t  out_data
);
  import pcmdma_pkg::*;

  logic skid_valid;
  res_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid && in_ready) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (in_valid && in_ready) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

/* sv/pcm_playback_dma_fifo_channel.sv */
// pcm playback dma channel: one command word in, one result word out
// a result is registered in the result register (or the skid, if the output stalls) as its command word is taken
// throughput: one command word every cycle while the skid is empty; all state updates in that cycle
// a two-deep output stage (result register plus skid) keeps input flowing
// reset (synchronous, active high) clears all state, config and the fifo
// depends on pcmdma_pkg, pcmdma_cmd_if, pcmdma_res_if, pcmdma_fifo, pcmdma_out_skid
module pcm_playback_dma_fifo_channel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pcmdma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmdma_pkg::CFG_DATA_W-1:0] cfg_data,
  pcmdma_cmd_if.sink                        cmd,
  pcmdma_res_if.source                      res
);
  import pcmdma_pkg::*;

  // configuration registers
  logic [31:0] base_address;
  logic [15:0] buffer_frames;
  logic [15:0] fragment_frames;
  fmt_t        sample_format;
  logic        interrupt_enable;
  logic        free_run;
  logic        paused;

  // channel state
  logic [31:0]        write_count, write_count_next;
  logic [31:0]        read_count, read_count_next;
  logic [31:0]        sample_pointer, sample_pointer_next;
  logic [31:0]        sample_byte_counter, sample_byte_counter_next;
  logic signed [16:0] buffer_counter, buffer_counter_next;
  logic signed [16:0] fragment_counter, fragment_counter_next;
  logic               restart_pending, restart_pending_next;
  logic               channel_active, channel_active_next;
  logic               fill_pending, fill_pending_next;
  logic               interrupt_flag, interrupt_flag_next;

  logic               accept;
  op_t                op;
  logic [31:0]        level;
  logic               grant;
  logic               fill_go;
  logic               skid_ready;
  logic [3:0][7:0]    fifo_bytes;
  logic signed [16:0] frag_dec;
  logic signed [16:0] buf_dec;
  logic [15:0]        left, right;
  res_t               result;
  res_t               res_data;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = skid_ready;
  assign op        = op_t'(cmd.operation);

  // ---------------------------------------------------------------
  // configuration writes, only expected while the channel is idle
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address     <= '0;
      buffer_frames    <= '0;
      fragment_frames  <= '0;
      sample_format    <= FMT_MONO8;
      interrupt_enable <= 1'b0;
      free_run         <= 1'b0;
      paused           <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_ADDRESS:     base_address     <= cfg_data;
        REG_BUFFER_FRAMES:    buffer_frames    <= cfg_data[15:0];
        REG_FRAGMENT_FRAMES:  fragment_frames  <= cfg_data[15:0];
        REG_SAMPLE_FORMAT:    sample_format    <= fmt_t'(cfg_data[1:0]);
        REG_INTERRUPT_ENABLE: interrupt_enable <= cfg_data[0];
        REG_FREE_RUN:         free_run         <= cfg_data[0];
        REG_PAUSED:           paused           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // fifo: level is the byte distance between writer and reader,
  // modulo 2^32; the reader window is the four bytes at read_count
  // ---------------------------------------------------------------
  assign level   = write_count - read_count;
  assign grant   = (op == OP_DMA_REQ) && channel_active && !paused &&
                   (free_run || level <= ROOM_LIMIT);
  assign fill_go = (op == OP_DMA_FILL) && fill_pending;

  pcmdma_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && fill_go),
    .wr_row   (write_count[POS_W-1:2]),
    .wr_word  (cmd.mem_word),
    .rd_pos   (read_count[POS_W-1:0]),
    .rd_bytes (fifo_bytes)
  );

  // fragment and buffer counters step down once per filled word
  assign frag_dec = count_down(fragment_counter);
  assign buf_dec  = count_down(buffer_counter);

  // ---------------------------------------------------------------
  // next state and result for the command word at the port
  // ---------------------------------------------------------------
  always_comb begin
    write_count_next         = write_count;
    read_count_next          = read_count;
    sample_pointer_next      = sample_pointer;
    sample_byte_counter_next = sample_byte_counter;
    buffer_counter_next      = buffer_counter;
    fragment_counter_next    = fragment_counter;
    restart_pending_next     = restart_pending;
    channel_active_next      = channel_active;
    fill_pending_next        = fill_pending;
    interrupt_flag_next      = interrupt_flag;
    left                     = '0;
    right                    = '0;

    unique case (op)
      OP_START: begin
        restart_pending_next = 1'b1;
        channel_active_next  = 1'b1;
      end
      OP_STOP: begin
        channel_active_next = 1'b0;
        fill_pending_next   = 1'b0;
      end
      OP_CLEAR_IRQ: begin
        interrupt_flag_next = 1'b0;
      end
      OP_DMA_REQ: begin
        if (grant) begin
          // a pending restart reloads pointer and counters first
          if (restart_pending) begin
            restart_pending_next     = 1'b0;
            sample_pointer_next      = base_address;
            buffer_counter_next      = $signed({1'b0, buffer_frames});
            sample_byte_counter_next = {16'd0, buffer_frames};
            fragment_counter_next    = $signed({1'b0, fragment_frames});
          end
          fill_pending_next = 1'b1;
        end
      end
      OP_DMA_FILL: begin
        if (fill_go) begin
          fill_pending_next   = 1'b0;
          write_count_next    = write_count + 32'd4;
          sample_pointer_next = sample_pointer + 32'd4;
          // fragment end reloads at once and may flag an interrupt
          if (frag_dec <= 17'sd0) begin
            fragment_counter_next = $signed({1'b0, fragment_frames});
            if (interrupt_enable) begin
              interrupt_flag_next = 1'b1;
            end
          end else begin
            fragment_counter_next = frag_dec;
          end
          // buffer end arms a restart for the next granted request
          buffer_counter_next = buf_dec;
          if (buf_dec <= 17'sd0) begin
            restart_pending_next = 1'b1;
          end
        end
      end
      OP_TICK: begin
        // too few bytes held gives silence and leaves the reader alone
        case (sample_format)
          FMT_MONO8: begin
            if (level >= 32'd1) begin
              left                     = unpack8(fifo_bytes[0]);
              right                    = left;
              read_count_next          = read_count + 32'd1;
              sample_byte_counter_next = sample_byte_counter - 32'd1;
            end
          end
          FMT_STEREO8: begin
            if (level >= 32'd2) begin
              left                     = unpack8(fifo_bytes[0]);
              right                    = unpack8(fifo_bytes[1]);
              read_count_next          = read_count + 32'd2;
              sample_byte_counter_next = sample_byte_counter - 32'd2;
            end
          end
          FMT_MONO16: begin
            if (level >= 32'd2) begin
              left                     = {fifo_bytes[1], fifo_bytes[0]};
              right                    = left;
              read_count_next          = read_count + 32'd2;
              sample_byte_counter_next = sample_byte_counter - 32'd2;
            end
          end
          default: begin
            if (level >= 32'd4) begin
              left                     = {fifo_bytes[1], fifo_bytes[0]};
              right                    = {fifo_bytes[3], fifo_bytes[2]};
              read_count_next          = read_count + 32'd4;
              sample_byte_counter_next = sample_byte_counter - 32'd4;
            end
          end
        endcase
      end
      default: ;  // unused codes only report status
    endcase

    result.left_sample          = $signed(left);
    result.right_sample         = $signed(right);
    result.fetch_valid          = grant;
    result.fetch_address        = sample_pointer_next;
    result.irq                  = interrupt_flag_next;
    result.frames_left          = buffer_counter_next[15:0];
    result.samples_left_quarter = sample_byte_counter_next[17:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count         <= '0;
      read_count          <= '0;
      sample_pointer      <= '0;
      sample_byte_counter <= '0;
      buffer_counter      <= '0;
      fragment_counter    <= '0;
      restart_pending     <= 1'b0;
      channel_active      <= 1'b0;
      fill_pending        <= 1'b0;
      interrupt_flag      <= 1'b0;
    end else if (accept) begin
      write_count         <= write_count_next;
      read_count          <= read_count_next;
      sample_pointer      <= sample_pointer_next;
      sample_byte_counter <= sample_byte_counter_next;
      buffer_counter      <= buffer_counter_next;
      fragment_counter    <= fragment_counter_next;
      restart_pending     <= restart_pending_next;
      channel_active      <= channel_active_next;
      fill_pending        <= fill_pending_next;
      interrupt_flag      <= interrupt_flag_next;
    end
  end

  // ---------------------------------------------------------------
  // result word: registered, with a skid word behind it
  // ---------------------------------------------------------------
  pcmdma_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (skid_ready),
    .in_data   (result),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_data)
  );

  assign res.left_sample          = res_data.left_sample;
  assign res.right_sample         = res_data.right_sample;
  assign res.fetch_valid          = res_data.fetch_valid;
  assign res.fetch_address        = res_data.fetch_address;
  assign res.irq                  = res_data.irq;
  assign res.frames_left          = res_data.frames_left;
  assign res.samples_left_quarter = res_data.samples_left_quarter;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_grant_arms_fill: assert property (@(posedge clk) disable iff (rst)
    accept && grant |=> fill_pending)
    else $error("granted request did not arm a fill");

  a_no_grant_idle: assert property (@(posedge clk) disable iff (rst)
    !channel_active |-> !grant)
    else $error("request granted on an inactive channel");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_STOP |=> !channel_active && !fill_pending)
    else $error("stop left the channel running");

  a_writer_aligned: assert property (@(posedge clk) disable iff (rst)
    write_count[1:0] == 2'd0)
    else $error("fifo writer lost word alignment");

  a_fill_advances: assert property (@(posedge clk) disable iff (rst)
    accept && fill_go |=> write_count == $past(write_count) + 32'd4)
    else $error("fill did not advance the writer by one word");

endmodule

/* test/pcm_playback_dma_fifo_channel_tb.sv */
// self-checking testbench for the pcm playback dma channel: command words in, status words out
// depends on pcmdma_pkg, pcmdma_cmd_if, pcmdma_res_if and the pcm_playback_dma_fifo_channel rtl
`timescale 1ns / 1ps

module pcm_playback_dma_fifo_channel_tb;
  import pcmdma_pkg::*;

  // the two operation codes with no function, exercised as noise
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_FROM   = 1000;   // no idling on either side in this window
  localparam int QUIET_TO     = 1600;
  localparam int HOLD_CYCLES  = 180;    // long receiver hold-off
  localparam int PHASE_WORDS  = 150;
  localparam int PHASE_COUNT  = 10;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] data;
  } cmd_word_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcmdma_cmd_if cmd ();
  pcmdma_res_if res ();

  pcm_playback_dma_fifo_channel DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd.sink),
    .res       (res.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // mirror of the channel: configuration and state
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_base;
  logic [15:0] cfg_buffer_frames;
  logic [15:0] cfg_fragment_frames;
  fmt_t        cfg_format;
  logic        cfg_irq_enable;
  logic        cfg_free_run;
  logic        cfg_paused;

  logic [7:0]  fifo_mirror [FIFO_BYTES];
  logic [31:0] fifo_wr_count;
  logic [31:0] fifo_rd_count;
  logic [31:0] play_ptr;
  logic [31:0] bytes_left;
  int          words_left;      // 17-bit buffer counter, kept as a plain int
  int          frag_left;       // 17-bit fragment counter
  logic        restart_armed;
  logic        chan_active;
  logic        fill_owed;
  logic        irq_flag;

  cmd_word_t cmd_backlog [$];   // command words still to be offered
  res_t      expected_results [$];

  int cycle_count   = 0;
  int mismatch_count = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  cmd_word_t drive_word;
  res_t      want;
  res_t      got;

  // byte index masked on its own, so words and 16-bit samples wrap bytewise
  function automatic logic [7:0] fifo_at(input logic [31:0] pos);
    return fifo_mirror[pos[POS_W-1:0]];
  endfunction

  // 8-bit sample: sign bit flipped, moved to the upper byte
  function automatic logic [15:0] take8();
    logic [7:0] b;
    b = fifo_at(fifo_rd_count);
    fifo_rd_count += 32'd1;
    return {b ^ 8'h80, 8'h00};
  endfunction

  function automatic logic [15:0] take16();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = fifo_at(fifo_rd_count);
    hi = fifo_at(fifo_rd_count + 32'd1);
    fifo_rd_count += 32'd2;
    return {hi, lo};
  endfunction

  // counters stop at the most negative 17-bit value
  function automatic int step_down(input int c);
    return (c > -65536) ? c - 1 : c;
  endfunction

  // next status word of the channel for one command word
  function automatic res_t predict_channel(input logic [2:0] op, input logic [31:0] data);
    res_t        r;
    logic [31:0] level;
    r     = '0;
    level = fifo_wr_count - fifo_rd_count;
    case (op)
      OP_START: begin
        restart_armed = 1'b1;
        chan_active   = 1'b1;
      end
      OP_STOP: begin
        chan_active = 1'b0;
        fill_owed   = 1'b0;
      end
      OP_CLEAR_IRQ: begin
        irq_flag = 1'b0;
      end
      OP_DMA_REQ: begin
        if (chan_active && !cfg_paused && (cfg_free_run || level <= ROOM_LIMIT)) begin
          if (restart_armed) begin
            restart_armed = 1'b0;
            play_ptr      = cfg_base;
            words_left    = int'(cfg_buffer_frames);
            bytes_left    = {16'h0000, cfg_buffer_frames};
            frag_left     = int'(cfg_fragment_frames);
          end
          r.fetch_valid = 1'b1;
          fill_owed     = 1'b1;
        end
      end
      OP_DMA_FILL: begin
        if (fill_owed) begin
          fill_owed = 1'b0;
          for (int i = 0; i < 4; i++) begin
            fifo_mirror[POS_W'(fifo_wr_count + 32'(i))] = data[8*i +: 8];
          end
          fifo_wr_count += 32'd4;
          play_ptr      += 32'd4;
          frag_left = step_down(frag_left);
          if (frag_left <= 0) begin
            frag_left = int'(cfg_fragment_frames);
            if (cfg_irq_enable) begin
              irq_flag = 1'b1;
            end
          end
          words_left = step_down(words_left);
          if (words_left <= 0) begin
            restart_armed = 1'b1;
          end
        end
      end
      OP_TICK: begin
        // too few bytes held: silence and nothing consumed
        case (cfg_format)
          FMT_MONO8: begin
            if (level >= 32'd1) begin
              r.left_sample  = take8();
              r.right_sample = r.left_sample;
              bytes_left    -= 32'd1;
            end
          end
          FMT_STEREO8: begin
            if (level >= 32'd2) begin
              r.left_sample  = take8();
              r.right_sample = take8();
              bytes_left    -= 32'd2;
            end
          end
          FMT_MONO16: begin
            if (level >= 32'd2) begin
              r.left_sample  = take16();
              r.right_sample = r.left_sample;
              bytes_left    -= 32'd2;
            end
          end
          default: begin
            if (level >= 32'd4) begin
              r.left_sample  = take16();
              r.right_sample = take16();
              bytes_left    -= 32'd4;
            end
          end
        endcase
      end
      default: begin
        // spare codes: status only
      end
    endcase
    r.fetch_address        = play_ptr;
    r.irq                  = irq_flag;
    r.frames_left          = words_left[15:0];
    r.samples_left_quarter = bytes_left[17:2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idling: a 13 in 100 chance per roll, none in the quiet window
  // ---------------------------------------------------------------------------
  function automatic bit idle_roll();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 13;
  endfunction

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: offers backlog words, predicts each word as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        expected_results.push_back(predict_channel(cmd.operation, cmd.mem_word));
      end
      // a held word stays on the bus until taken
      if (!cmd.valid || cmd.ready) begin
        if (cmd_backlog.size() != 0 && !idle_roll()) begin
          drive_word     = cmd_backlog.pop_front();
          cmd.valid     <= 1'b1;
          cmd.operation <= drive_word.op;
          cmd.mem_word  <= drive_word.data;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each status word against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        results_seen++;
        got.left_sample          = res.left_sample;
        got.right_sample         = res.right_sample;
        got.fetch_valid          = res.fetch_valid;
        got.fetch_address        = res.fetch_address;
        got.irq                  = res.irq;
        got.frames_left          = res.frames_left;
        got.samples_left_quarter = res.samples_left_quarter;
        if (expected_results.size() == 0) begin
          $error("status word with no expectation waiting");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("left_sample", 32'(want.left_sample), 32'(got.left_sample));
          check_field("right_sample", 32'(want.right_sample), 32'(got.right_sample));
          check_field("fetch_valid", 32'(want.fetch_valid), 32'(got.fetch_valid));
          check_field("fetch_address", want.fetch_address, got.fetch_address);
          check_field("irq", 32'(want.irq), 32'(got.irq));
          check_field("frames_left", 32'(want.frames_left), 32'(got.frames_left));
          check_field("samples_left_quarter", 32'(want.samples_left_quarter),
                      32'(got.samples_left_quarter));
        end
        // now and then a long hold-off so the output stage fills and input stalls
        if (results_seen % 400 == 150) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= !idle_roll();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input logic [2:0] op, input logic [31:0] data);
    cmd_word_t w;
    w.op   = op;
    w.data = data;
    cmd_backlog.push_back(w);
  endfunction

  // settle point: nothing left to offer, on the bus or in flight
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (cmd_backlog.size() != 0 || cmd.valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_BASE_ADDRESS:     cfg_base            = value;
      REG_BUFFER_FRAMES:    cfg_buffer_frames   = value[15:0];
      REG_FRAGMENT_FRAMES:  cfg_fragment_frames = value[15:0];
      REG_SAMPLE_FORMAT:    cfg_format          = fmt_t'(value[1:0]);
      REG_INTERRUPT_ENABLE: cfg_irq_enable      = value[0];
      REG_FREE_RUN:         cfg_free_run        = value[0];
      REG_PAUSED:           cfg_paused          = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] base, input logic [15:0] buf_frames,
                            input logic [15:0] frag_frames, input fmt_t fmt,
                            input logic irq_en, input logic run_always,
                            input logic hold_fetch);
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_BUFFER_FRAMES, 32'(buf_frames));
    write_reg(REG_FRAGMENT_FRAMES, 32'(frag_frames));
    write_reg(REG_SAMPLE_FORMAT, 32'(fmt));
    write_reg(REG_INTERRUPT_ENABLE, 32'(irq_en));
    write_reg(REG_FREE_RUN, 32'(run_always));
    write_reg(REG_PAUSED, 32'(hold_fetch));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly request/fill pairs and ticks, with stops, clears and stray words mixed in
  function automatic void queue_playback(input int n);
    int made;
    int roll;
    made = 1;
    queue_word(OP_START, $urandom());
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        queue_word(OP_DMA_REQ, $urandom());
        queue_word(OP_DMA_FILL, $urandom());
        made += 2;
      end else if (roll < 75) begin
        queue_word(OP_TICK, $urandom());
        made++;
      end else if (roll < 80) begin
        queue_word(OP_CLEAR_IRQ, $urandom());
        made++;
      end else if (roll < 82) begin
        queue_word(OP_STOP, $urandom());
        made++;
      end else if (roll < 85) begin
        queue_word(OP_START, $urandom());
        made++;
      end else if (roll < 92) begin
        queue_word(OP_DMA_REQ, $urandom());
        made++;
      end else if (roll < 96) begin
        queue_word(OP_DMA_FILL, $urandom());
        made++;
      end else begin
        queue_word(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B, $urandom());
        made++;
      end
    end
  endfunction

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_BASE_ADDRESS;
    cfg_data      = '0;
    cmd.valid     = 1'b0;
    cmd.operation = OP_START;
    cmd.mem_word  = '0;
    res.ready     = 1'b0;

    // mirror starts from the reset state
    cfg_base            = '0;
    cfg_buffer_frames   = '0;
    cfg_fragment_frames = '0;
    cfg_format          = FMT_MONO8;
    cfg_irq_enable      = 1'b0;
    cfg_free_run        = 1'b0;
    cfg_paused          = 1'b0;
    for (int i = 0; i < FIFO_BYTES; i++) begin
      fifo_mirror[i] = 8'h00;
    end
    fifo_wr_count = '0;
    fifo_rd_count = '0;
    play_ptr      = '0;
    bytes_left    = '0;
    words_left    = 0;
    frag_left     = 0;
    restart_armed = 1'b0;
    chan_active   = 1'b0;
    fill_owed     = 1'b0;
    irq_flag      = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: short buffer and fragment near the top of the address space
    set_config(32'hFFFF_FFF0, 16'd3, 16'd2, FMT_MONO8, 1'b1, 1'b0, 1'b0);
    queue_word(OP_TICK, 32'h0);               // empty fifo gives silence
    queue_word(OP_DMA_FILL, 32'h1234_5678);   // fill with no granted request
    queue_word(OP_DMA_REQ, 32'h0);            // inactive channel, no grant
    queue_word(OP_START, 32'h0);
    queue_word(OP_DMA_REQ, 32'h0);            // restart reloads pointer and counters
    queue_word(OP_DMA_FILL, 32'hFFFF_FFFF);
    queue_word(OP_DMA_REQ, 32'h0);
    queue_word(OP_DMA_FILL, 32'h0000_0000);   // fragment end raises the flag
    queue_word(OP_TICK, 32'h0);
    queue_word(OP_TICK, 32'h0);
    queue_word(OP_TICK, 32'h0);
    queue_word(OP_CLEAR_IRQ, 32'h0);
    queue_word(OP_DMA_REQ, 32'h0);
    queue_word(OP_DMA_FILL, 32'h807F_01FE);   // buffer end arms a restart
    queue_word(OP_DMA_REQ, 32'h0);            // armed restart performed here
    queue_word(OP_DMA_FILL, 32'hA5A5_A5A5);
    queue_word(OP_SPARE_A, 32'hFFFF_FFFF);
    queue_word(OP_SPARE_B, 32'h0);
    queue_word(OP_STOP, 32'h0);
    queue_word(OP_DMA_FILL, 32'h5A5A_5A5A);   // no fill is owed here, so the word is dropped
    queue_word(OP_DMA_REQ, 32'h0);
    queue_word(OP_TICK, 32'h0);
    queue_word(OP_TICK, 32'h0);
    wait_drained();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: set_config($urandom(), 16'd5, 16'd2, FMT_STEREO16, 1'b1, 1'b0, 1'b0);
        1: set_config(32'h0000_0000, 16'd0, 16'd0, FMT_MONO16, 1'b1, 1'b0, 1'b0);
        2: set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, FMT_STEREO8, 1'b0, 1'b0, 1'b0);
        // fetch regardless of room: older bytes are overwritten
        3: set_config($urandom(), 16'($urandom_range(1, 9)), 16'($urandom_range(0, 4)),
                      fmt_t'($urandom_range(0, 3)), 1'b1, 1'b1, 1'b0);
        4: set_config($urandom(), 16'($urandom_range(0, 9)), 16'($urandom_range(0, 4)),
                      fmt_t'($urandom_range(0, 3)), 1'b1, 1'b0, 1'b1);
        default: set_config($urandom(), 16'($urandom_range(0, 20)),
                            16'($urandom_range(0, 8)), fmt_t'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 4) == 0),
                            1'($urandom_range(0, 9) == 0));
      endcase
      queue_playback(PHASE_WORDS);
      wait_drained();
    end

    // wait past the last status word for anything stray
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* pcm_playback_dma_fifo_channel.f */
sv/pcmdma_pkg.sv
sv/pcmdma_cmd_if.sv
sv/pcmdma_res_if.sv
sv/pcmdma_fifo.sv
sv/pcmdma_out_skid.sv
sv/pcm_playback_dma_fifo_channel.sv
test/pcm_playback_dma_fifo_channel_tb.sv
